/* hw/rtl/rfpc_pkg.sv */
`default_nettype none

package rfpc_pkg;

  // channel plan and reading width
  localparam int CHANNEL_COUNT = 40;
  localparam int READING_BITS  = 12;
  localparam int CHAN_W        = 6;
  localparam int SWEEP_W       = 8;
  localparam int PHASE_W       = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [READING_BITS-1:0] READING_MAX = {READING_BITS{1'b1}};
  localparam logic [SWEEP_W-1:0]      SWEEP_MAX   = {SWEEP_W{1'b1}};

  // calibration phases
  localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SCAN_LOW  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SCAN_HIGH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE      = 3'd4;

  // request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS_NEEDED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVERSITY_ENABLE = 1'd1;

  // reset values of the configuration registers
  localparam logic [SWEEP_W-1:0] SWEEPS_NEEDED_RST    = 8'd10;
  localparam logic               DIVERSITY_ENABLE_RST = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic                    reading_stable;
    logic [READING_BITS-1:0] strength_a;
    logic [READING_BITS-1:0] strength_b;
    logic                    mode_short_press;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]      phase;
    logic [CHAN_W-1:0]       tune_channel;
    logic [READING_BITS-1:0] floor_a;
    logic [READING_BITS-1:0] floor_b;
    logic [READING_BITS-1:0] peak_a;
    logic [READING_BITS-1:0] peak_b;
    logic                    save_pulse;
    logic                    refresh_pulse;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/rfpc_if.sv */
`default_nettype none

// input word channel
interface rfpc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic                              reading_stable;
  logic [rfpc_pkg::READING_BITS-1:0] strength_a;
  logic [rfpc_pkg::READING_BITS-1:0] strength_b;
  logic                              mode_short_press;

  modport source (
    output valid, req_type, reading_stable, strength_a, strength_b, mode_short_press,
    input  ready
  );
  modport sink (
    input  valid, req_type, reading_stable, strength_a, strength_b, mode_short_press,
    output ready
  );
endinterface

// result word channel
interface rfpc_out_if;
  logic                              valid;
  logic                              ready;
  logic [rfpc_pkg::PHASE_W-1:0]      phase;
  logic [rfpc_pkg::CHAN_W-1:0]       tune_channel;
  logic [rfpc_pkg::READING_BITS-1:0] floor_a;
  logic [rfpc_pkg::READING_BITS-1:0] floor_b;
  logic [rfpc_pkg::READING_BITS-1:0] peak_a;
  logic [rfpc_pkg::READING_BITS-1:0] peak_b;
  logic                              save_pulse;
  logic                              refresh_pulse;

  modport source (
    output valid, phase, tune_channel, floor_a, floor_b, peak_a, peak_b,
           save_pulse, refresh_pulse,
    input  ready
  );
  modport sink (
    input  valid, phase, tune_channel, floor_a, floor_b, peak_a, peak_b,
           save_pulse, refresh_pulse,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/rfpc_in_stage.sv */
`default_nettype none

module rfpc_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rfpc_pkg::item_t in_item_i,
  input  wire logic            out_free_i,
  output logic                 adv_o,
  output rfpc_pkg::item_t      item_o
);

  logic            valid_q;
  logic            valid_d;
  rfpc_pkg::item_t item_q;

  // word moves on when the result register can take it
  assign adv_o      = valid_q && out_free_i;
  assign in_ready_o = !valid_q || adv_o;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !adv_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rfpc_core.sv */
`default_nettype none

module rfpc_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rfpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rfpc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                adv_i,
  input  wire rfpc_pkg::item_t                     item_i,
  output rfpc_pkg::result_t                        res_o
);

  logic [rfpc_pkg::SWEEP_W-1:0]      sweeps_needed_q;
  logic                              diversity_q;

  logic [rfpc_pkg::PHASE_W-1:0]      phase_q, phase_d;
  logic [rfpc_pkg::CHAN_W-1:0]       chan_q, chan_d;
  logic [rfpc_pkg::SWEEP_W-1:0]      sweep_q, sweep_d;
  logic [rfpc_pkg::READING_BITS-1:0] floor_a_q, floor_a_d;
  logic [rfpc_pkg::READING_BITS-1:0] floor_b_q, floor_b_d;
  logic [rfpc_pkg::READING_BITS-1:0] peak_a_q, peak_a_d;
  logic [rfpc_pkg::READING_BITS-1:0] peak_b_q, peak_b_d;
  logic                              save;
  logic                              refresh;

  logic [rfpc_pkg::CHAN_W:0]         chan_inc;
  logic                              wrap;
  logic [rfpc_pkg::SWEEP_W-1:0]      sweep_inc;
  logic                              scan_end;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweeps_needed_q <= rfpc_pkg::SWEEPS_NEEDED_RST;
      diversity_q     <= rfpc_pkg::DIVERSITY_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfpc_pkg::CFG_SWEEPS_NEEDED:    sweeps_needed_q <= cfg_wdata_i;
        rfpc_pkg::CFG_DIVERSITY_ENABLE: diversity_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // channel stepping and sweep count for a stable tick
  assign chan_inc  = {1'b0, chan_q} + 7'd1;
  assign wrap      = chan_inc >= 7'(rfpc_pkg::CHANNEL_COUNT);
  assign sweep_inc = (sweep_q == rfpc_pkg::SWEEP_MAX) ? sweep_q : sweep_q + 8'd1;
  assign scan_end  = wrap && (sweep_inc == sweeps_needed_q);

  // next state for one word
  always_comb begin
    phase_d   = phase_q;
    chan_d    = chan_q;
    sweep_d   = sweep_q;
    floor_a_d = floor_a_q;
    floor_b_d = floor_b_q;
    peak_a_d  = peak_a_q;
    peak_b_d  = peak_b_q;
    save      = 1'b0;
    refresh   = 1'b0;
    if (item_i.req_type == rfpc_pkg::REQ_TICK) begin
      if (item_i.reading_stable) begin
        // fold readings into running extremes
        unique case (phase_q)
          rfpc_pkg::PH_SCAN_LOW: begin
            if (item_i.strength_a < floor_a_q) floor_a_d = item_i.strength_a;
            if (diversity_q && item_i.strength_b < floor_b_q) floor_b_d = item_i.strength_b;
          end
          rfpc_pkg::PH_SCAN_HIGH: begin
            if (item_i.strength_a > peak_a_q) peak_a_d = item_i.strength_a;
            if (diversity_q && item_i.strength_b > peak_b_q) peak_b_d = item_i.strength_b;
          end
          default: ;
        endcase
        chan_d = wrap ? '0 : chan_inc[rfpc_pkg::CHAN_W-1:0];
        if (wrap) begin
          sweep_d = sweep_inc;
        end
        if (scan_end && phase_q == rfpc_pkg::PH_SCAN_LOW) begin
          phase_d = rfpc_pkg::PH_WAIT_HIGH;
          refresh = 1'b1;
        end else if (scan_end && phase_q == rfpc_pkg::PH_SCAN_HIGH) begin
          phase_d = rfpc_pkg::PH_DONE;
          refresh = 1'b1;
        end
      end
    end else if (item_i.mode_short_press) begin
      // button handling per phase
      unique case (phase_q)
        rfpc_pkg::PH_WAIT_LOW: begin
          phase_d   = rfpc_pkg::PH_SCAN_LOW;
          sweep_d   = '0;
          chan_d    = '0;
          floor_a_d = rfpc_pkg::READING_MAX;
          if (diversity_q) floor_b_d = rfpc_pkg::READING_MAX;
          refresh   = 1'b1;
        end
        rfpc_pkg::PH_WAIT_HIGH: begin
          phase_d  = rfpc_pkg::PH_SCAN_HIGH;
          sweep_d  = '0;
          chan_d   = '0;
          peak_a_d = '0;
          if (diversity_q) peak_b_d = '0;
          refresh  = 1'b1;
        end
        rfpc_pkg::PH_DONE: begin
          phase_d = rfpc_pkg::PH_WAIT_LOW;
          save    = 1'b1;
          refresh = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rfpc_pkg::PH_WAIT_LOW;
      chan_q    <= '0;
      sweep_q   <= '0;
      floor_a_q <= rfpc_pkg::READING_MAX;
      floor_b_q <= rfpc_pkg::READING_MAX;
      peak_a_q  <= '0;
      peak_b_q  <= '0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      chan_q    <= chan_d;
      sweep_q   <= sweep_d;
      floor_a_q <= floor_a_d;
      floor_b_q <= floor_b_d;
      peak_a_q  <= peak_a_d;
      peak_b_q  <= peak_b_d;
    end
  end

  // result reflects the state after this word
  always_comb begin
    res_o.phase         = phase_d;
    res_o.tune_channel  = chan_d;
    res_o.floor_a       = floor_a_d;
    res_o.floor_b       = floor_b_d;
    res_o.peak_a        = peak_a_d;
    res_o.peak_b        = peak_b_d;
    res_o.save_pulse    = save;
    res_o.refresh_pulse = refresh;
  end

endmodule

`default_nettype wire

/* hw/rtl/rfpc_out_stage.sv */
`default_nettype none

module rfpc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire rfpc_pkg::result_t res_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_free_o,
  output rfpc_pkg::result_t      res_o
);

  logic              valid_q;
  logic              valid_d;
  rfpc_pkg::result_t res_q;

  // register is free when empty or being drained
  assign out_free_o  = !valid_q || out_ready_i;
  assign valid_d     = adv_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rssi_floor_peak_calibrator.sv */
// channel  direction  handshake       payload
// in_i     sink       valid / ready   req_type, reading_stable, strength_a/b, mode_short_press
// out_o    source     valid / ready   phase, tune_channel, floor/peak a/b, save/refresh pulses
// cfg      write      cfg_we_i        cfg_idx_i, cfg_wdata_i
//
// A word passes from acceptance to result through the input register, then
// the compare/update logic feeding the result register. One word per clock
// is sustained while out_o is ready; the rate is set by the state update in the core.
// Reset is asynchronous, active low, and clears state and both valid flags.
// A stalled result register holds the input register, which then drops ready.
`default_nettype none

module rssi_floor_peak_calibrator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rfpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rfpc_in_if.sink                              in_i,
  rfpc_out_if.source                           out_o
);

  rfpc_pkg::item_t   in_item;
  rfpc_pkg::item_t   item;
  rfpc_pkg::result_t res_d;
  rfpc_pkg::result_t res_q;
  logic              adv;
  logic              out_free;

  // gather input payload
  always_comb begin
    in_item.req_type         = in_i.req_type;
    in_item.reading_stable   = in_i.reading_stable;
    in_item.strength_a       = in_i.strength_a;
    in_item.strength_b       = in_i.strength_b;
    in_item.mode_short_press = in_i.mode_short_press;
  end

  rfpc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .adv_o      (adv),
    .item_o     (item)
  );

  rfpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (item),
    .res_o       (res_d)
  );

  rfpc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_i       (res_d),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_free_o  (out_free),
    .res_o       (res_q)
  );

  // scatter result payload
  assign out_o.phase         = res_q.phase;
  assign out_o.tune_channel  = res_q.tune_channel;
  assign out_o.floor_a       = res_q.floor_a;
  assign out_o.floor_b       = res_q.floor_b;
  assign out_o.peak_a        = res_q.peak_a;
  assign out_o.peak_b        = res_q.peak_b;
  assign out_o.save_pulse    = res_q.save_pulse;
  assign out_o.refresh_pulse = res_q.refresh_pulse;

  // a save always comes with a refresh and lands in wait-low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.save_pulse |->
      out_o.refresh_pulse && out_o.phase == rfpc_pkg::PH_WAIT_LOW)
    else $error("save pulse without refresh or outside wait-low");

  // tuned channel stays inside the channel plan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 7'({1'b0, out_o.tune_channel}) < 7'(rfpc_pkg::CHANNEL_COUNT))
    else $error("tune channel beyond channel count");

  // a refresh into wait-high or done only follows a wrap to channel 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.refresh_pulse &&
      (out_o.phase == rfpc_pkg::PH_WAIT_HIGH || out_o.phase == rfpc_pkg::PH_DONE) |->
      out_o.tune_channel == '0)
    else $error("scan ended without channel wrap");

  // the input register only drains into a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_o.valid)
    else $error("result lost after input advance");

endmodule

`default_nettype wire
